// ===== hdl/ssnpc_pkg.sv =====
// ============================================================================
// ssnpc_pkg: shared types and decode constants for the single-step planner
// Opcode masks and patterns, stop kinds and the result word layout.
// ============================================================================
`default_nettype none

package ssnpc_pkg;

    // Opcode masks
    localparam logic [15:0] MASK_COND  = 16'hff00;
    localparam logic [15:0] MASK_UBR   = 16'he000;
    localparam logic [15:0] MASK_REGBR = 16'hf0df;

    // Opcode patterns
    localparam logic [15:0] OP_BT    = 16'h8900;
    localparam logic [15:0] OP_BTS   = 16'h8d00;
    localparam logic [15:0] OP_BF    = 16'h8b00;
    localparam logic [15:0] OP_BFS   = 16'h8f00;
    localparam logic [15:0] OP_BRA   = 16'ha000;
    localparam logic [15:0] OP_JSR   = 16'h400b;
    localparam logic [15:0] OP_RTS   = 16'h000b;
    localparam logic [15:0] OP_RTE   = 16'h002b;
    localparam logic [15:0] OP_TRAPA = 16'hc300;

    // Kind of stop to place
    typedef enum logic [1:0] {
        KIND_PATCH = 2'd0,
        KIND_TRAP  = 2'd1,
        KIND_HWBP  = 2'd2
    } stop_kind_t;

    // One result word
    typedef struct packed {
        stop_kind_t  stop_kind;
        logic [31:0] target_address;
        logic [7:0]  trap_number;
    } stop_plan_t;

endpackage

`default_nettype wire

// ===== hdl/ssnpc_decode.sv =====
// ============================================================================
// ssnpc_decode: instruction decode and next-pc computation
// Classifies one instruction word and forms the stop kind, stop address
// and trap number. Pure combinational, one address adder.
// ============================================================================
`default_nettype none

module ssnpc_decode (
    input  wire logic [15:0]          instruction_word,
    input  wire logic [31:0]          current_pc,
    input  wire logic                 t_flag,
    input  wire logic [31:0]          register_value,
    input  wire logic [31:0]          return_address,
    output ssnpc_pkg::stop_plan_t     plan
);
    import ssnpc_pkg::*;

    logic [15:0] hi;
    logic        is_bt;
    logic        is_bf;
    logic        is_slot;
    logic        taken;
    logic [31:0] disp8;
    logic [31:0] disp12;
    logic [31:0] offset;
    logic [31:0] pc_sum;

    assign hi      = instruction_word & MASK_COND;
    assign is_bt   = (hi == OP_BT) || (hi == OP_BTS);
    assign is_bf   = (hi == OP_BF) || (hi == OP_BFS);
    assign is_slot = (hi == OP_BTS) || (hi == OP_BFS);
    assign taken   = (is_bt && t_flag) || (is_bf && !t_flag);

    // Doubled, sign-extended branch displacements
    assign disp8  = {{23{instruction_word[7]}}, instruction_word[7:0], 1'b0};
    assign disp12 = {{19{instruction_word[11]}}, instruction_word[11:0], 1'b0};

    // Offset added to pc for every pc-relative case
    always_comb
    begin
        priority if (taken)
        begin
            offset = disp8 + 32'd4;
        end
        else if (is_bt || is_bf)
        begin
            offset = is_slot ? 32'd4 : 32'd2;
        end
        else if ((instruction_word & MASK_UBR) == OP_BRA)
        begin
            offset = disp12 + 32'd4;
        end
        else
        begin
            offset = 32'd2;
        end
    end

    assign pc_sum = current_pc + offset;

    // Final selection of kind and address
    always_comb
    begin
        plan.stop_kind      = KIND_PATCH;
        plan.target_address = pc_sum;
        plan.trap_number    = 8'd0;
        priority if (is_bt || is_bf || ((instruction_word & MASK_UBR) == OP_BRA))
        begin
            plan.target_address = pc_sum;
        end
        else if ((instruction_word & MASK_REGBR) == OP_JSR)
        begin
            plan.target_address = register_value;
        end
        else if (instruction_word == OP_RTS)
        begin
            plan.target_address = return_address;
        end
        else if (instruction_word == OP_RTE)
        begin
            plan.stop_kind      = KIND_HWBP;
            plan.target_address = current_pc;
        end
        else if (hi == OP_TRAPA)
        begin
            plan.stop_kind      = KIND_TRAP;
            plan.target_address = 32'd0;
            plan.trap_number    = instruction_word[7:0];
        end
        else
        begin
            plan.target_address = pc_sum;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sh_single_step_next_pc.sv =====
// Path: an accepted word is held in the input register, then the plan in the result register.
// Throughput: one word per cycle when out_stall is low; decode and the single address
// adder sit between the input register and the result register.
// Reset: rst_n asynchronous active low; clears both stage valid flags,
// the pipeline comes up empty. Payload registers are not reset.
// ============================================================================
// sh_single_step_next_pc: single-step stop planner
// Registers each instruction word, decodes where the next single-step stop
// goes, and holds the plan in an output register under valid/stall flow.
// ============================================================================
`default_nettype none

module sh_single_step_next_pc (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] instruction_word,
    input  wire logic [31:0] current_pc,
    input  wire logic        t_flag,
    input  wire logic [31:0] register_value,
    input  wire logic [31:0] return_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       stop_kind,
    output logic [31:0]      target_address,
    output logic [7:0]       trap_number
);
    import ssnpc_pkg::*;

    logic        in_valid_reg;
    logic [15:0] word_reg;
    logic [31:0] pc_reg;
    logic        t_reg;
    logic [31:0] rv_reg;
    logic [31:0] pr_reg;
    logic        out_valid_reg;
    stop_plan_t  plan_reg;
    stop_plan_t  plan_next;
    logic        adv_out;
    logic        adv_in;

    // Stage advance: each stage moves when empty or when the next one takes it
    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_in   = !in_valid_reg || adv_out;
    assign in_stall = !adv_in;

    // Input register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv_in)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && in_valid)
        begin
            word_reg <= instruction_word;
            pc_reg   <= current_pc;
            t_reg    <= t_flag;
            rv_reg   <= register_value;
            pr_reg   <= return_address;
        end
    end

    // Decode
    ssnpc_decode u_decode (
        .instruction_word (word_reg),
        .current_pc       (pc_reg),
        .t_flag           (t_reg),
        .register_value   (rv_reg),
        .return_address   (pr_reg),
        .plan             (plan_next)
    );

    // Result register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && in_valid_reg)
        begin
            plan_reg <= plan_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stop_kind      = plan_reg.stop_kind;
    assign target_address = plan_reg.target_address;
    assign trap_number    = plan_reg.trap_number;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ============================================================================
// tb_top: testbench for the single-step stop planner
// Feeds instruction words with random gaps and takes result words under
// random back-pressure. A scoreboard predicts each stop plan from the
// decode rules and checks every result word in order, field by field.
// ============================================================================
`default_nettype none

module tb_top;

    import ssnpc_pkg::*;

    // ------------------------------------------------------------------------
    // Stop plan scoreboard: predicts plans for accepted words, checks results
    // ------------------------------------------------------------------------
    class stop_plan_board;
        stop_plan_t pending_plans[$];
        int         fail_count;

        function new();
            fail_count = 0;
        endfunction

        // Where the next single-step stop goes for one instruction
        function stop_plan_t plan_stop(logic [15:0] w, logic [31:0] pc, logic t,
                                       logic [31:0] rv, logic [31:0] pr);
            stop_plan_t  p;
            logic [15:0] hi;
            logic [31:0] short_hop;
            logic [31:0] long_hop;
            hi        = w & MASK_COND;
            // 8-bit and 12-bit displacements, doubled and sign-extended
            short_hop = pc + 32'd4 + {{23{w[7]}}, w[7:0], 1'b0};
            long_hop  = pc + 32'd4 + {{19{w[11]}}, w[11:0], 1'b0};
            p.stop_kind   = KIND_PATCH;
            p.trap_number = 8'd0;
            if (hi == OP_BT || hi == OP_BTS)
            begin
                if (t)
                    p.target_address = short_hop;
                else
                    p.target_address = pc + ((hi == OP_BTS) ? 32'd4 : 32'd2);
            end
            else if (hi == OP_BF || hi == OP_BFS)
            begin
                if (!t)
                    p.target_address = short_hop;
                else
                    p.target_address = pc + ((hi == OP_BFS) ? 32'd4 : 32'd2);
            end
            else if ((w & MASK_UBR) == OP_BRA)
                p.target_address = long_hop;
            else if ((w & MASK_REGBR) == OP_JSR)
                p.target_address = rv;
            else if (w == OP_RTS)
                p.target_address = pr;
            else if (w == OP_RTE)
            begin
                p.stop_kind      = KIND_HWBP;
                p.target_address = pc;
            end
            else if (hi == OP_TRAPA)
            begin
                p.stop_kind      = KIND_TRAP;
                p.target_address = 32'd0;
                p.trap_number    = w[7:0];
            end
            else
                p.target_address = pc + 32'd2;
            return p;
        endfunction

        // Accepted input word: queue its expected plan
        function void note_word(logic [15:0] w, logic [31:0] pc, logic t,
                                logic [31:0] rv, logic [31:0] pr);
            pending_plans.push_back(plan_stop(w, pc, t, rv, pr));
        endfunction

        // Accepted result word: compare with the oldest expected plan
        function void check_plan(logic [1:0] kind, logic [31:0] target,
                                 logic [7:0] trap);
            stop_plan_t e;
            if (pending_plans.size() == 0)
            begin
                $error("unexpected result word: stop_kind %0d target_address %h",
                       kind, target);
                fail_count++;
                return;
            end
            e = pending_plans.pop_front();
            if (kind !== e.stop_kind)
            begin
                $error("stop_kind: expected %0d, actual %0d", e.stop_kind, kind);
                fail_count++;
            end
            if (target !== e.target_address)
            begin
                $error("target_address: expected %h, actual %h",
                       e.target_address, target);
                fail_count++;
            end
            if (trap !== e.trap_number)
            begin
                $error("trap_number: expected %h, actual %h", e.trap_number, trap);
                fail_count++;
            end
        endfunction

        function int pending();
            return pending_plans.size();
        endfunction

        // Expectations that never got a result word
        function void flush_leftovers();
            while (pending_plans.size() != 0)
            begin
                void'(pending_plans.pop_front());
                $error("expected result word never arrived");
                fail_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        in_valid         = 1'b0;
    logic        in_stall;
    logic [15:0] instruction_word = 16'd0;
    logic [31:0] current_pc       = 32'd0;
    logic        t_flag           = 1'b0;
    logic [31:0] register_value   = 32'd0;
    logic [31:0] return_address   = 32'd0;
    logic        out_valid;
    logic        out_stall        = 1'b0;
    logic [1:0]  stop_kind;
    logic [31:0] target_address;
    logic [7:0]  trap_number;

    // no idling on either side while set
    bit steady_flow = 1'b0;

    stop_plan_board sb = new();

    always #4 clk = ~clk;

    sh_single_step_next_pc u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .instruction_word (instruction_word),
        .current_pc       (current_pc),
        .t_flag           (t_flag),
        .register_value   (register_value),
        .return_address   (return_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .stop_kind        (stop_kind),
        .target_address   (target_address),
        .trap_number      (trap_number)
    );

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    function automatic int draw_wait();
        return steady_flow ? 0 : $urandom_range(0, 3);
    endfunction

    // pc mostly random, sometimes near the wrap points
    function automatic logic [31:0] draw_pc();
        case ($urandom_range(0, 5))
            0:       return 32'hffff_fff0 | $urandom_range(0, 15);
            1:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Offer one word with a random lead-in gap, hold it until accepted
    task automatic send_word(input logic [15:0] w, input logic [31:0] pc,
                             input logic t, input logic [31:0] rv,
                             input logic [31:0] pr);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        instruction_word <= w;
        current_pc       <= pc;
        t_flag           <= t;
        register_value   <= rv;
        return_address   <= pr;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(w, pc, t, rv, pr);
    endtask

    // Random instruction word, mostly from the decoded classes
    function automatic logic [15:0] draw_word();
        logic [15:0] cond_ops[4];
        cond_ops = '{OP_BT, OP_BTS, OP_BF, OP_BFS};
        case ($urandom_range(0, 9))
            0, 1:    return cond_ops[$urandom_range(0, 3)] | 16'($urandom_range(0, 255));
            2:       return OP_BRA | 16'($urandom_range(0, 1) << 12)
                            | 16'($urandom_range(0, 4095));
            3:       return OP_JSR | 16'($urandom_range(0, 15) << 8)
                            | 16'($urandom_range(0, 1) << 5);
            4:       return OP_RTS;
            5:       return OP_RTE;
            6:       return OP_TRAPA | 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall before each word, then take it
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_plan(stop_kind, target_address, trap_number);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every branch class, displacement signs, wrap, traps
        send_word(OP_BT  | 16'h007f, 32'h0000_1000, 1'b1, $urandom, $urandom);
        send_word(OP_BT  | 16'h0080, 32'h0000_1000, 1'b1, $urandom, $urandom);
        send_word(OP_BT  | 16'h0055, 32'hffff_fffe, 1'b0, $urandom, $urandom);
        send_word(OP_BTS | 16'h0010, 32'hffff_fffe, 1'b0, $urandom, $urandom);
        send_word(OP_BTS | 16'h00ff, 32'h0000_0000, 1'b1, $urandom, $urandom);
        send_word(OP_BF  | 16'h0080, 32'h0000_0002, 1'b0, $urandom, $urandom);
        send_word(OP_BF  | 16'h0001, 32'h8000_0000, 1'b1, $urandom, $urandom);
        send_word(OP_BFS | 16'h0020, 32'hffff_fffc, 1'b1, $urandom, $urandom);
        send_word(OP_BFS | 16'h007f, 32'hffff_ff00, 1'b0, $urandom, $urandom);
        send_word(OP_BRA | 16'h07ff, 32'hffff_f000, 1'b0, $urandom, $urandom);
        send_word(OP_BRA | 16'h0800, 32'h0000_0100, 1'b1, $urandom, $urandom);
        send_word(16'hbfff, 32'h0000_0000, 1'b0, $urandom, $urandom);
        send_word(16'hb000, 32'h1234_5678, 1'b1, $urandom, $urandom);
        send_word(OP_JSR, $urandom, 1'b0, 32'hffff_ffff, $urandom);
        send_word(16'h4f2b, $urandom, 1'b1, 32'h0000_0000, $urandom);
        send_word(OP_RTS, $urandom, 1'b0, $urandom, 32'hffff_ffff);
        send_word(OP_RTS, $urandom, 1'b1, $urandom, 32'h0000_0001);
        send_word(OP_RTE, 32'hffff_ffff, 1'b0, $urandom, $urandom);
        send_word(OP_TRAPA, $urandom, 1'b0, $urandom, $urandom);
        send_word(OP_TRAPA | 16'h00ff, 32'h0000_0003, 1'b1, $urandom, $urandom);
        send_word(16'h0009, 32'hffff_ffff, 1'b0, $urandom, $urandom);
        send_word(16'h0000, 32'h0000_0000, 1'b1, $urandom, $urandom);
        send_word(16'hffff, 32'hffff_fffe, 1'b0, $urandom, $urandom);
        send_word(16'h8a80, 32'h0000_0010, 1'b1, $urandom, $urandom);
        send_word(16'h401b, 32'h0000_0020, 1'b0, $urandom, $urandom);

        // Random words, with stretches of back-to-back flow
        for (int i = 0; i < 1400; i++)
        begin
            steady_flow = ((i / 100) % 4 == 3);
            send_word(draw_word(), draw_pc(), 1'($urandom_range(0, 1)), $urandom,
                      $urandom);
        end
        in_valid    <= 1'b0;
        steady_flow = 1'b0;

        // Drain, then wait on for anything stray before the final check
        waited = 0;
        while (sb.pending() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        sb.flush_leftovers();
        if (sb.fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
